FILE: hw/rtl/rtcs_pkg.sv
// Shared types and codes for the textured wall column shader.
// No dependencies; used by the top level and its checker.
package rtcs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_COLUMN = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKY_COLOR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 2'd3;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  texture_select;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
    logic [11:0] column;
    logic [15:0] wall_x;
    logic [15:0] line_height;
    logic [10:0] draw_start;
    logic [11:0] draw_end;
    logic [10:0] row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [22:0] pixel_address;
  } out_item_t;

endpackage

FILE: hw/rtl/rtcs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module rtcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read data only changes on a read access
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/raycast_textured_column_shader_top.sv
// Textured wall column shader: texture loads, column setup, per-row pixel shading.
// Throughput: one item per cycle unless out_stall holds a result; set by the $clog2(TEX_H)
// restoring divider stages and the single texture RAM port, which a load or a textured pixel
// uses once as it leaves the last stage.
// Reset (rst_n, synchronous): resets stage valids, output valid, column state and registers;
// the texture memory is not cleared and reads as garbage until written. Uses rtcs_pkg, rtcs_ram.
module raycast_textured_column_shader_top #(
  parameter int TEX_W        = 64,
  parameter int TEX_H        = 64,
  parameter int NUM_TEXTURES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rtcs_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rtcs_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rtcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int TEX_WORDS = TEX_W * TEX_H;
  localparam int DEPTH     = NUM_TEXTURES * TEX_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int TXW       = $clog2(TEX_W);
  localparam int QB        = $clog2(TEX_H);     // quotient bits = divider stages
  localparam int TBW       = $clog2(TEX_H + 1);
  localparam int RW        = 24 + TBW;          // dividend width after scaling by TEX_H
  localparam int NP        = QB + 2;            // pipe stages before the RAM access

  // One record per stage. Loads reuse color as write data and mem_addr as the
  // write address; pixels carry the texture column address and divider state.
  typedef struct packed {
    logic          load;
    logic          use_tex;
    logic          sat;
    logic [31:0]   color;
    logic [AW-1:0] mem_addr;
    logic [22:0]   pix_addr;
    logic [RW-1:0] rem;
    logic [15:0]   den;
    logic [QB-1:0] quo;
  } stage_t;

  // configuration registers
  logic [12:0] scr_w_r;
  logic [11:0] scr_h_r;
  logic [31:0] sky_r;
  logic [31:0] floor_r;

  // column state
  logic [11:0]    cur_col_r;
  logic [1:0]     side_r;
  logic [TXW-1:0] tex_x_r;
  logic [15:0]    lh_r;
  logic [10:0]    span_start_r;
  logic [11:0]    span_end_r;

  // pipeline
  stage_t        st_r   [NP];
  stage_t        st_nxt [NP];
  logic [NP-1:0] st_vld_r;
  logic [NP:0]   en;

  // output stage
  logic        out_valid_r;
  logic        out_use_tex_r;
  logic [31:0] out_color_r;
  logic [22:0] out_addr_r;

  // input decode
  logic              accept;
  logic              load_ok;
  logic              keep_item;
  logic [31:0]       wx_scaled;
  logic [TXW-1:0]    tex_x_nxt;
  logic [15:0]       lh_nxt;
  logic signed [25:0] d;
  logic              d_pos;
  logic              d_sat;
  logic              in_span;
  logic [23:0]       addr_full;

  // RAM access side
  stage_t        last;
  logic [QB-1:0] texy;
  logic [AW-1:0] ram_addr;
  logic          ram_en;
  logic [31:0]   ram_rdata;

  //--------------------------------------------------------------------------
  // Stall chain: a stage takes a new record when it is empty or its record
  // moves on. The output register frees as soon as out_stall drops, so the
  // input keeps flowing while a result waits only if some stage is empty.
  //--------------------------------------------------------------------------
  always_comb begin
    en[NP] = !out_valid_r || !out_stall;
    for (int k = NP - 1; k >= 0; k--) begin
      en[k] = !st_vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign accept   = in_valid && en[0];

  // Loads outside the texture set or the texture size are dropped; column
  // items only touch the column state; an unknown kind is dropped.
  assign load_ok   = (int'(in_data.texture_select) < NUM_TEXTURES) &&
                     (int'(in_data.texel_index) < TEX_WORDS);
  assign keep_item = (in_data.kind == rtcs_pkg::KIND_PIXEL) ||
                     ((in_data.kind == rtcs_pkg::KIND_LOAD) && load_ok);

  // mirrored texture column: TEX_W-1 - floor(wall_x*TEX_W / 2^16)
  assign wx_scaled = 32'(in_data.wall_x) * 32'(TEX_W);
  assign tex_x_nxt = TXW'(32'(TEX_W - 1) - (wx_scaled >> 16));
  assign lh_nxt    = (in_data.line_height == 16'd0) ? 16'd1 : in_data.line_height;

  //--------------------------------------------------------------------------
  // Stage 0: texel row offset d = row*256 - H*128 + lh*128, and the early
  // outcomes. d <= 0 gives texel row 0; d >= lh*256 saturates to TEX_H-1;
  // otherwise the quotient d*TEX_H / (lh*256) is below TEX_H.
  //--------------------------------------------------------------------------
  assign d = $signed({7'b0, in_data.row, 8'b0}) - $signed({7'b0, scr_h_r, 7'b0})
           + $signed({3'b0, lh_r, 7'b0});
  assign d_pos = d > 26'sd0;
  assign d_sat = d >= $signed({2'b0, lh_r, 8'b0});

  assign in_span   = (in_data.row >= span_start_r) && ({1'b0, in_data.row} < span_end_r);
  assign addr_full = 24'(scr_w_r) * 24'(in_data.row) + 24'(cur_col_r);

  always_comb begin
    st_nxt[0] = '0;
    if (in_data.kind == rtcs_pkg::KIND_LOAD) begin
      st_nxt[0].load     = 1'b1;
      st_nxt[0].color    = in_data.texel_value;
      st_nxt[0].mem_addr = AW'(32'(in_data.texture_select) * TEX_WORDS
                               + 32'(in_data.texel_index));
    end else begin
      // a wall row with no such texture shades to zero
      st_nxt[0].use_tex  = in_span && (int'(side_r) < NUM_TEXTURES);
      st_nxt[0].sat      = d_sat;
      st_nxt[0].mem_addr = AW'(32'(side_r) * TEX_WORDS + 32'(tex_x_r));
      st_nxt[0].pix_addr = addr_full[22:0];
      st_nxt[0].den      = lh_r;
      st_nxt[0].rem      = (d_pos && !d_sat) ? RW'(d[23:0]) : '0;
      if (in_span) begin
        st_nxt[0].color = 32'd0;
      end else if ({1'b0, in_data.row} < (scr_h_r >> 1)) begin
        st_nxt[0].color = sky_r;
      end else begin
        st_nxt[0].color = floor_r;
      end
    end
  end

  // Stage 1: scale the dividend by the texture height
  always_comb begin
    st_nxt[1]     = st_r[0];
    st_nxt[1].rem = st_r[0].rem * RW'(TEX_H);
  end

  // Stages 2..NP-1: one restoring quotient bit each, MSB first, against lh*256
  for (genvar k = 2; k < NP; k++) begin : g_div
    localparam int B = NP - 1 - k;
    logic [RW-1:0] dshift;
    always_comb begin
      dshift    = RW'({st_r[k-1].den, 8'b0}) << B;
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].rem >= dshift) begin
        st_nxt[k].rem    = st_r[k-1].rem - dshift;
        st_nxt[k].quo[B] = 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // RAM access as a record leaves the last stage. Loads and pixel reads use
  // the one port in item order, so a read always sees every earlier load.
  // The read data register holds while the output stalls.
  //--------------------------------------------------------------------------
  assign last     = st_r[NP-1];
  assign texy     = last.sat ? QB'(TEX_H - 1) : last.quo;
  assign ram_addr = last.load ? last.mem_addr
                              : last.mem_addr + AW'(32'(texy) * TEX_W);
  assign ram_en   = en[NP] && st_vld_r[NP-1] && (last.load || last.use_tex);

  rtcs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_tex_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (last.load),
    .addr  (ram_addr),
    .wdata (last.color),
    .rdata (ram_rdata)
  );

  //--------------------------------------------------------------------------
  // Control registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r     <= '0;
      out_valid_r  <= 1'b0;
      scr_w_r      <= rtcs_pkg::SCREEN_WIDTH_RST;
      scr_h_r      <= rtcs_pkg::SCREEN_HEIGHT_RST;
      sky_r        <= '0;
      floor_r      <= '0;
      cur_col_r    <= '0;
      side_r       <= '0;
      tex_x_r      <= '0;
      lh_r         <= 16'd1;
      span_start_r <= '0;
      span_end_r   <= '0;
    end else begin
      if (en[0]) begin
        st_vld_r[0] <= in_valid && keep_item;
      end
      for (int k = 1; k < NP; k++) begin
        if (en[k]) begin
          st_vld_r[k] <= st_vld_r[k-1];
        end
      end
      if (en[NP]) begin
        out_valid_r <= st_vld_r[NP-1] && !last.load;
      end

      if (accept && (in_data.kind == rtcs_pkg::KIND_COLUMN)) begin
        cur_col_r    <= in_data.column;
        side_r       <= in_data.texture_select;
        tex_x_r      <= tex_x_nxt;
        lh_r         <= lh_nxt;
        span_start_r <= in_data.draw_start;
        span_end_r   <= in_data.draw_end;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          rtcs_pkg::REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata[12:0];
          rtcs_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata[11:0];
          rtcs_pkg::REG_SKY_COLOR:     sky_r   <= cfg_wdata;
          rtcs_pkg::REG_FLOOR_COLOR:   floor_r <= cfg_wdata;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < NP; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (en[NP]) begin
      out_use_tex_r <= last.use_tex;
      out_color_r   <= last.color;
      out_addr_r    <= last.pix_addr;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.pixel_color   = out_use_tex_r ? ram_rdata : out_color_r;
  assign out_data.pixel_address = out_addr_r;

endmodule

FILE: hw/rtl/rtcs_checker.sv
// Port-level checks for the column shader top level, bound to it below.
// Uses rtcs_pkg.
module rtcs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input rtcs_pkg::out_item_t             out_data
);

  // input backs up only when a result is held by the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  // a held result stays and does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind raycast_textured_column_shader_top rtcs_checker u_rtcs_checker (.*);
